>>> hw/rtl/mmx_pkg.sv
// Package for the MIXMAX matrix generator: widths, reset values, register
// indexes and the Mersenne-61 helper functions.
// No dependencies.
package mmx_pkg;

    localparam int WORD_W      = 62;            // stored word, may exceed p slightly
    localparam int CFG_W       = 61;            // widest configuration register
    localparam int CFG_IDX_W   = 2;
    localparam int VEC_LEN_DEF = 240;
    localparam int SEED_W      = 8;

    localparam logic [60:0] P61 = 61'h1FFF_FFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_COEFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATIONS    = 2'd3;

    // special term modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_NEGATE = 2'd1;
    localparam logic [1:0] MODE_MUL    = 2'd2;

    localparam logic [1:0]  RST_MODE  = MODE_MUL;
    localparam logic [60:0] RST_COEFF = 61'd487013230256099140;
    localparam logic [5:0]  RST_ROT   = 6'd51;
    localparam logic [1:0]  RST_ITERS = 2'd1;
    localparam logic [5:0]  ROT_MAX   = 6'd60;

    // partial fold: (x & p) + (x >> 61)
    function automatic logic [WORD_W-1:0] fold61(input logic [63:0] x);
        return {1'b0, x[60:0]} + {59'd0, x[63:61]};
    endfunction

    // 61-bit rotate left of a partial sum, r in 1..60
    function automatic logic [60:0] rot61(input logic [WORD_W-1:0] k, input logic [5:0] r);
        logic [63:0] hi_part;
        logic [63:0] lo_part;
        hi_part = ({2'b00, k} << r) & {3'b000, P61};
        lo_part = {2'b00, k} >> (7'd61 - {1'b0, r});
        return hi_part[60:0] | lo_part[60:0];
    endfunction

endpackage

>>> hw/rtl/mmx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on mmx_pkg for default sizes.
module mmx_ram
    import mmx_pkg::*;
#(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = VEC_LEN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/mmx_mulmod.sv
// Multi-cycle a*b mod 2^61-1 with partial folds, built from four 32x32
// partial products. Depends on mmx_pkg (fold61, widths).
module mmx_mulmod
    import mmx_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [60:0]       i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic              o_done,
    output logic [WORD_W-1:0] o_result
);

    localparam int ACC_W = 123;   // 61 + 62 bit product

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_PP   = 2'd1;
    localparam logic [1:0] M_SUM  = 2'd2;
    localparam logic [1:0] M_FOLD = 2'd3;

    logic [1:0]        r_state;
    logic [2:0]        r_cnt;
    logic              r_ppv;
    logic [1:0]        r_pp_sel;
    logic [63:0]       r_pp;
    logic [60:0]       r_a;
    logic [WORD_W-1:0] r_b;
    logic [ACC_W-1:0]  r_acc;
    logic [63:0]       r_s;
    logic [WORD_W-1:0] r_res;
    logic              r_done;

    logic [31:0]      op_x;
    logic [31:0]      op_y;
    logic [ACC_W-1:0] pp_shifted;
    logic [63:0]      acc_lo;
    logic [58:0]      acc_hi;
    logic [63:0]      n_s;

    // cnt 0: al*bl, 1: al*bh, 2: ah*bl, 3: ah*bh
    assign op_x = r_cnt[1] ? {3'b000, r_a[60:32]} : r_a[31:0];
    assign op_y = r_cnt[0] ? {2'b00, r_b[61:32]} : r_b[31:0];

    always_comb begin
        case (r_pp_sel)
            2'd0:    pp_shifted = ACC_W'(r_pp);
            2'd3:    pp_shifted = ACC_W'(r_pp) << 64;
            default: pp_shifted = ACC_W'(r_pp) << 32;
        endcase
    end

    assign acc_lo = r_acc[63:0];
    assign acc_hi = r_acc[ACC_W-1:64];
    assign n_s    = {3'b000, acc_lo[60:0]} + {2'b00, acc_hi, 3'b000} + {61'd0, acc_lo[63:61]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_ppv   <= 1'b0;
            r_cnt   <= 3'd0;
        end else begin
            r_done <= (r_state == M_FOLD);
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_acc   <= '0;
                        r_cnt   <= 3'd0;
                        r_ppv   <= 1'b0;
                        r_state <= M_PP;
                    end
                end
                M_PP: begin
                    if (r_cnt != 3'd4) begin
                        r_pp     <= {32'd0, op_x} * {32'd0, op_y};
                        r_pp_sel <= r_cnt[1:0];
                        r_cnt    <= r_cnt + 3'd1;
                    end
                    r_ppv <= (r_cnt != 3'd4);
                    if (r_ppv) begin
                        r_acc <= r_acc + pp_shifted;
                    end
                    if (r_cnt == 3'd4) begin
                        r_state <= M_SUM;
                    end
                end
                M_SUM: begin
                    r_s     <= n_s;
                    r_state <= M_FOLD;
                end
                M_FOLD: begin
                    r_res   <= fold61(r_s);
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

>>> hw/rtl/mixmax_matrix_rng_unit.sv
// MIXMAX matrix generator over p = 2^61-1, top level.
// Depends on mmx_pkg, mmx_ram (state vector store) and mmx_mulmod (special term).
//
// A draw request returns the next word of the stored state vector; a reseed
// request loads the unit vector at seed_index (value 0, seed_error set and
// state kept when the index is not below VECTOR_LEN). For a draw from the
// stored vector the accept cycle issues the RAM read and S_RD then loads the
// output register once it is free. When the vector is used up the draw
// refills it first: each matrix iteration walks the vector (one RAM read and
// one write-back per word through a 3-stage pipeline), then, when a special
// term is set, adds it to word two by a read-modify-write (in multiply mode
// the term takes 4 partial products in the multiplier and a fold), and last
// folds the running sum. The output register lets a new request be accepted
// while the previous result still waits. After reset and after a reseed the
// RAM contents are masked by per-word valid bits, so no clearing pass is run.
module mixmax_matrix_rng_unit
    import mmx_pkg::*;
#(
    parameter int VECTOR_LEN = VEC_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  logic [SEED_W-1:0]    i_seed_index,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [WORD_W-1:0]    o_value,
    output logic                 o_seed_error,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int ADDR_W = $clog2(VECTOR_LEN);
    localparam int POS_W  = $clog2(VECTOR_LEN + 1);
    localparam int OVF_W  = $clog2(VECTOR_LEN + 1);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VECTOR_LEN - 1);
    localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_TWO  = ADDR_W'(2);
    localparam logic [POS_W-1:0]  POS_END   = POS_W'(VECTOR_LEN);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD     = 4'd1;   // result from RAM data to output reg
    localparam logic [3:0] S_START  = 4'd2;   // word 0 <= running sum, init walk
    localparam logic [3:0] S_WALK   = 4'd3;
    localparam logic [3:0] S_NEG1   = 4'd4;
    localparam logic [3:0] S_NEG2   = 4'd5;
    localparam logic [3:0] S_EXTM   = 4'd6;
    localparam logic [3:0] S_EXT_RD = 4'd7;
    localparam logic [3:0] S_W2     = 4'd8;
    localparam logic [3:0] S_FIN1   = 4'd9;
    localparam logic [3:0] S_FIN2   = 4'd10;

    // configuration
    logic [1:0]  r_mode;
    logic [60:0] r_coeff;
    logic [5:0]  r_rot;
    logic [1:0]  r_iters;

    // architectural state outside the RAM
    logic [3:0]          r_state;
    logic [POS_W-1:0]    r_read_pos;
    logic [WORD_W-1:0]   r_run_sum;
    logic [VECTOR_LEN-1:0] r_valid;       // RAM word written since last (re)seed
    logic [ADDR_W-1:0]   r_seed_pos;      // where the one sits in unwritten words
    logic [1:0]          r_iter;

    // request bookkeeping
    logic r_is_seed;
    logic r_bad_seed;

    // RAM read tag
    logic r_rd_vbit;
    logic r_rd_one;

    // walk pipeline
    logic              r_issue;
    logic [ADDR_W-1:0] r_idx;
    logic              r_s1v, r_s2v, r_s3v;
    logic [ADDR_W-1:0] r_s1i, r_s2i;
    logic [WORD_W-1:0] r_part;
    logic [60:0]       r_rp;
    logic [WORD_W-1:0] r_v;
    logic [WORD_W-1:0] r_s3val;
    logic [63:0]       r_sum;
    logic [OVF_W-1:0]  r_ovf;
    logic [WORD_W-1:0] r_first;
    logic [WORD_W-1:0] r_ext;

    // output register
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_value;
    logic              r_out_err;

    logic              in_acc;
    logic              out_free;
    logic [5:0]        rot_eff;
    logic              use_extra;
    logic              walk_done;
    logic              mul_start;
    logic              mul_done;
    logic [WORD_W-1:0] mul_res;
    logic              seed_ok;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] rd_word;

    logic [WORD_W-1:0] n_part;
    logic [WORD_W-1:0] n_v;
    logic [64:0]       n_sum_walk;
    logic [64:0]       n_sum_ext;
    logic [WORD_W-1:0] n_red;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_vld || !i_out_stall;
    assign rot_eff   = (r_rot > ROT_MAX) ? ROT_MAX : r_rot;
    assign use_extra = (r_mode == MODE_NEGATE) || (r_mode == MODE_MUL && r_coeff != '0);
    assign walk_done = !r_issue && !r_s1v && !r_s2v && !r_s3v;
    assign mul_start = (r_state == S_WALK) && walk_done && r_mode == MODE_MUL && use_extra;
    assign seed_ok   = 9'(i_seed_index) < 9'(VECTOR_LEN);

    // unwritten words read as the unit vector
    assign rd_word = r_rd_vbit ? ram_rdata : {{(WORD_W-1){1'b0}}, r_rd_one};

    // recurrence datapath
    assign n_part     = fold61(64'(r_part) + 64'(rd_word));
    assign n_v        = fold61(64'(r_v) + 64'(r_part) + 64'(r_rp));
    assign n_sum_walk = {1'b0, r_sum} + 65'(r_s3val);
    assign n_sum_ext  = {1'b0, r_sum} + 65'(r_ext);
    // conditional subtract of p, used for the negate term
    assign n_red      = (r_ext > {1'b0, P61}) ? r_ext - {1'b0, P61} : r_ext;

    // RAM write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        if (r_state == S_START) begin
            ram_we    = 1'b1;
            ram_wdata = r_run_sum;
        end else if (r_s2v) begin
            ram_we    = 1'b1;
            ram_waddr = r_s2i;
            ram_wdata = n_v;
        end else if (r_state == S_W2) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_TWO;
            ram_wdata = fold61(64'(rd_word) + 64'(r_ext));
        end
    end

    // RAM read port
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (r_state == S_IDLE && in_acc && !i_req_type && r_read_pos != POS_END) begin
            ram_re    = 1'b1;
            ram_raddr = r_read_pos[ADDR_W-1:0];
        end else if (r_state == S_WALK && r_issue) begin
            ram_re    = 1'b1;
            ram_raddr = r_idx;
        end else if (r_state == S_EXT_RD) begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_TWO;
        end else if (r_state == S_FIN2 && r_iter <= 2'd1) begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_ONE;
        end
    end

    mmx_ram #(
        .WIDTH (WORD_W),
        .DEPTH (VECTOR_LEN)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mmx_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (r_coeff),
        .i_b      (r_first),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_coeff <= RST_COEFF;
            r_rot   <= RST_ROT;
            r_iters <= RST_ITERS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPECIAL_MODE:  r_mode  <= i_cfg_data[1:0];
                CFG_SPECIAL_COEFF: r_coeff <= i_cfg_data[60:0];
                CFG_ROTATE:        r_rot   <= i_cfg_data[5:0];
                CFG_ITERATIONS:    r_iters <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // RAM read tag: valid bit and unit-vector position travel with the data
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_rd_vbit <= r_valid[ram_raddr];
            r_rd_one  <= (ram_raddr == r_seed_pos);
        end
    end

    // walk pipeline datapath (stage 1: partial sum, 2: new word, 3: sum)
    always_ff @(posedge i_clk) begin
        if (r_s1v) begin
            r_part <= n_part;
            r_rp   <= (rot_eff == 6'd0) ? 61'd0 : rot61(r_part, rot_eff);
            if (r_s1i == ADDR_ONE) begin
                r_first <= rd_word;
            end
        end
        r_s1i <= r_idx;
        r_s2i <= r_s1i;
        if (r_s2v) begin
            r_v <= n_v;
        end
        r_s3val <= n_v;

        if (r_state == S_START) begin
            r_part <= '0;
            r_v    <= r_run_sum;
            r_sum  <= 64'(r_run_sum);
            r_ovf  <= '0;
        end else if (r_s3v) begin
            r_sum <= n_sum_walk[63:0];
            r_ovf <= r_ovf + OVF_W'(n_sum_walk[64]);
        end else if (r_state == S_W2) begin
            r_sum <= n_sum_ext[63:0];
            r_ovf <= r_ovf + OVF_W'(n_sum_ext[64]);
        end else if (r_state == S_FIN1) begin
            r_sum <= 64'(fold61(r_sum));
        end

        // special term
        if (r_state == S_WALK && walk_done) begin
            r_ext <= (r_first > {1'b0, P61}) ? r_first - {1'b0, P61} : r_first;
        end else if (r_state == S_NEG1) begin
            r_ext <= n_red;
        end else if (r_state == S_NEG2) begin
            r_ext <= {1'b0, P61} - r_ext;
        end else if (r_state == S_EXTM && mul_done) begin
            r_ext <= mul_res;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_read_pos <= POS_END;
            r_run_sum  <= {{(WORD_W-1){1'b0}}, 1'b1};
            r_valid    <= '0;
            r_seed_pos <= '0;
            r_iter     <= 2'd1;
            r_issue    <= 1'b0;
            r_idx      <= '0;
            r_s1v      <= 1'b0;
            r_s2v      <= 1'b0;
            r_s3v      <= 1'b0;
            r_out_vld  <= 1'b0;
            r_is_seed  <= 1'b0;
            r_bad_seed <= 1'b0;
        end else begin
            r_s1v <= r_issue && r_state == S_WALK;
            r_s2v <= r_s1v;
            r_s3v <= r_s2v;

            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end

            // S_RD refills the output register itself
            if (r_out_vld && !i_out_stall && r_state != S_RD) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_is_seed  <= i_req_type;
                        r_bad_seed <= i_req_type && !seed_ok;
                        if (i_req_type) begin
                            if (seed_ok) begin
                                r_valid    <= '0;
                                r_seed_pos <= i_seed_index[ADDR_W-1:0];
                                r_read_pos <= POS_END;
                                r_run_sum  <= {{(WORD_W-1){1'b0}}, 1'b1};
                            end
                            r_state <= S_RD;
                        end else if (r_read_pos != POS_END) begin
                            r_read_pos <= r_read_pos + POS_W'(1);
                            r_state    <= S_RD;
                        end else begin
                            r_iter  <= (r_iters == 2'd0) ? 2'd1 : r_iters;
                            r_state <= S_START;
                        end
                    end
                end
                S_RD: begin
                    if (out_free) begin
                        r_out_vld   <= 1'b1;
                        r_out_value <= r_is_seed ? '0 : rd_word;
                        r_out_err   <= r_bad_seed;
                        r_state     <= S_IDLE;
                    end
                end
                S_START: begin
                    r_idx   <= ADDR_ONE;
                    r_issue <= 1'b1;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (r_issue) begin
                        if (r_idx == LAST_ADDR) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + ADDR_W'(1);
                        end
                    end else if (walk_done) begin
                        if (!use_extra) begin
                            r_state <= S_FIN1;
                        end else if (r_mode == MODE_NEGATE) begin
                            r_state <= S_NEG1;
                        end else begin
                            r_state <= S_EXTM;
                        end
                    end
                end
                S_NEG1:   r_state <= S_NEG2;
                S_NEG2:   r_state <= S_EXT_RD;
                S_EXTM: begin
                    if (mul_done) begin
                        r_state <= S_EXT_RD;
                    end
                end
                S_EXT_RD: r_state <= S_W2;
                S_W2:     r_state <= S_FIN1;
                S_FIN1:   r_state <= S_FIN2;
                S_FIN2: begin
                    r_run_sum <= fold61(r_sum + 64'({r_ovf, 3'b000}));
                    if (r_iter > 2'd1) begin
                        r_iter  <= r_iter - 2'd1;
                        r_state <= S_START;
                    end else begin
                        r_read_pos <= POS_W'(2);
                        r_is_seed  <= 1'b0;
                        r_bad_seed <= 1'b0;
                        r_state    <= S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_value      = r_out_value;
    assign o_seed_error = r_out_err;

    // the walk reads ahead of its write-back, never the same word
    a_no_rw_same_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("RAM read and write hit the same word");

    // read position stays between word 2 and the end marker
    a_read_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_read_pos >= POS_W'(2) && r_read_pos <= POS_END)
        else $error("read position out of range");

    // walk pipeline only carries words during the walk
    a_pipe_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1v || r_s2v || r_s3v) |-> r_state == S_WALK)
        else $error("walk pipeline active outside the walk");

    // multiplier results only arrive while the special term waits for them
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> r_state == S_EXTM)
        else $error("multiplier result outside special-term wait");

    // an accepted request always leaves idle
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("request accepted without starting work");

endmodule
